FILE: hw/rtl/cht_pkg.sv
package cht_pkg;

    // Request kinds
    localparam logic [1:0] KIND_CREATE = 2'd0;
    localparam logic [1:0] KIND_FIRE   = 2'd1;
    localparam logic [1:0] KIND_PRUNE  = 2'd2;

    // Reply status codes
    localparam logic [2:0] ST_CREATED    = 3'd0;
    localparam logic [2:0] ST_NO_HANDLER = 3'd1;
    localparam logic [2:0] ST_FIRED      = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd3;
    localparam logic [2:0] ST_PRUNED     = 3'd4;

    // Eviction LFSR seed
    localparam logic [15:0] LFSR_SEED = 16'hACE1;

    typedef struct packed {
        logic [1:0]         kind;
        logic [15:0]        handler_tag;
        logic [15:0]        context_tag;
        logic signed [63:0] now;
        logic [31:0]        handle;
        logic signed [63:0] time_limit;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] new_handle;
        logic        evicted;
        logic [15:0] found_handler;
        logic [15:0] found_context;
        logic [3:0]  freed_count;
        logic [3:0]  occupied;
    } t_out_word;

    // One table entry as held in memory
    typedef struct packed {
        logic [15:0]        id;
        logic [15:0]        handler;
        logic [15:0]        context_tag;
        logic signed [63:0] created;
    } t_entry;

endpackage

FILE: hw/rtl/cht_ram.sv
module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/cht_evict.sv
module cht_evict
    import cht_pkg::*;
#(
    parameter int SLOTS = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    output logic                                   o_done,
    output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] o_slot
);

    localparam int          SW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam bit          POW2    = ((SLOTS & (SLOTS - 1)) == 0);
    localparam logic [15:0] MASK    = 16'(SLOTS - 1);
    // Reciprocal of SLOTS scaled by 2^32, rounded up; exact for 16-bit dividends
    localparam logic [63:0] RECIP64 = ((64'd1 << 32) + 64'(SLOTS - 1)) / 64'(SLOTS);
    localparam logic [32:0] RECIP   = RECIP64[32:0];

    logic [15:0] r_lfsr;
    logic        r_busy;
    logic        r_step;
    logic        r_done;
    logic [15:0] r_rem;
    logic [15:0] r_quot;
    logic [15:0] n_lfsr;
    logic [47:0] w_prod;
    logic [15:0] w_qs;

    // Advance the LFSR: taps 16,14,13,11, shift right
    assign n_lfsr = {r_lfsr[0] ^ r_lfsr[2] ^ r_lfsr[3] ^ r_lfsr[5], r_lfsr[15:1]};

    // Quotient by reciprocal multiply, then quotient times SLOTS
    assign w_prod = 48'(r_rem) * 48'(RECIP);
    assign w_qs   = r_quot * 16'(SLOTS);

    // Control: LFSR, busy and done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr <= LFSR_SEED;
            r_busy <= 1'b0;
            r_step <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= i_start ? POW2 : (r_busy && r_step);
            if (i_start) begin
                r_lfsr <= n_lfsr;
                r_busy <= !POW2;
                r_step <= 1'b0;
            end else if (r_busy) begin
                r_step <= 1'b1;
                if (r_step) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Reduce the new LFSR value modulo SLOTS: by mask, or quotient then remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= POW2 ? (n_lfsr & MASK) : n_lfsr;
        end else if (r_busy) begin
            if (!r_step) begin
                r_quot <= w_prod[47:32];
            end else begin
                r_rem <= r_rem - w_qs;
            end
        end
    end

    assign o_done = r_done;
    assign o_slot = r_rem[SW-1:0];

endmodule

FILE: hw/rtl/callback_handle_table.sv
// Channel | Dir | Handshake                 | Payload
// input   | in  | i_in_valid / o_in_ready   | i_in_data  (t_in_word)
// output  | out | o_out_valid / i_out_ready | o_out_data (t_out_word)
//
// One request at a time. Fire reads the entry on accept, then checks it and fills the result register.
// Create runs the free-slot scan of 8 valid bits a cycle, then writes the entry;
// an eviction picks a victim by mask (SLOTS a power of two) or by reciprocal-multiply modulo.
// Prune walks the entry memory one entry a cycle.
// Synchronous active-low reset clears valid bits, counters and the LFSR; no clearing pass.
// A new request is taken while the previous result waits; a stalled output holds the next.
module callback_handle_table
    import cht_pkg::*;
#(
    parameter int SLOTS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_data
);

    localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LW  = $clog2(SLOTS + 1);
    localparam int NCH = (SLOTS + 7) / 8;
    localparam int CW  = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int EW  = $bits(t_entry);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_EVICT  = 3'd2;
    localparam logic [2:0] S_CWR    = 3'd3;
    localparam logic [2:0] S_FIRE   = 3'd4;
    localparam logic [2:0] S_PRUNE  = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]       r_state;
    logic [SLOTS-1:0] r_valid;
    logic [LW-1:0]    r_live;
    logic [15:0]      r_id;
    t_in_word         r_in;
    logic [CW-1:0]    r_chunk;
    logic [SW-1:0]    r_slot;
    logic             r_evicted;
    logic [SW:0]      r_idx;
    logic             r_pend;
    logic [SW-1:0]    r_pidx;
    logic [LW-1:0]    r_freed;
    t_out_word        r_res;
    t_out_word        r_out;
    logic             r_ovalid;

    logic              w_accept;
    logic [NCH*8-1:0]  w_vpad;
    logic [7:0]        w_cbits;
    logic              w_any;
    logic [2:0]        w_j;
    logic [CW+2:0]     w_found_full;
    logic              w_last_chunk;
    logic              w_ev_start;
    logic              w_ev_done;
    logic [SW-1:0]     w_ev_slot;
    logic [15:0]       w_id_inc;
    logic [15:0]       w_id_next;
    logic              w_we;
    logic              w_re;
    logic [SW-1:0]     w_raddr;
    t_entry            w_wentry;
    logic [EW-1:0]     w_rdata;
    t_entry            w_rentry;
    logic [SW-1:0]     w_fslot;
    logic              w_fmatch;
    logic              w_idx_end;
    logic              w_old;
    t_out_word         w_res_init;
    t_out_word         w_res_out;
    logic              w_load;

    assign w_accept   = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);

    // Scan eight valid bits a cycle for the lowest free slot
    always_comb begin
        w_vpad = '1;
        w_vpad[SLOTS-1:0] = r_valid;
        w_cbits = w_vpad[r_chunk*8 +: 8];
        w_any = 1'b0;
        w_j = 3'd0;
        for (int j = 7; j >= 0; j--) begin
            if (!w_cbits[j]) begin
                w_any = 1'b1;
                w_j = 3'(j);
            end
        end
    end

    assign w_found_full = {r_chunk, w_j};
    assign w_last_chunk = (r_chunk == CW'(NCH - 1));
    assign w_ev_start   = (r_state == S_SEARCH) && !w_any && w_last_chunk;

    // Id counter skips zero
    assign w_id_inc  = r_id + 16'd1;
    assign w_id_next = (w_id_inc == 16'd0) ? 16'd1 : w_id_inc;

    // Entry memory ports
    assign w_we     = (r_state == S_CWR);
    assign w_wentry = '{id: w_id_next, handler: r_in.handler_tag,
                        context_tag: r_in.context_tag, created: r_in.now};
    assign w_idx_end = (r_idx == (SW + 1)'(SLOTS));
    assign w_re = (w_accept && i_in_data.kind == KIND_FIRE)
               || (r_state == S_PRUNE && !w_idx_end);
    assign w_raddr = (r_state == S_PRUNE) ? r_idx[SW-1:0] : i_in_data.handle[16 +: SW];
    assign w_rentry = t_entry'(w_rdata);

    // Fire lookup and prune age check
    assign w_fslot  = r_in.handle[16 +: SW];
    assign w_fmatch = (r_in.handle[31:16] < 16'(SLOTS)) && r_valid[w_fslot]
                   && (w_rentry.id == r_in.handle[15:0]);
    assign w_old    = r_pend && r_valid[r_pidx]
                   && ($signed(w_rentry.created) < $signed(r_in.time_limit));

    // Start each reply cleared but for a default status: no handler for create, not found otherwise
    always_comb begin
        w_res_init        = '0;
        w_res_init.status = (i_in_data.kind == KIND_CREATE) ? ST_NO_HANDLER : ST_NOT_FOUND;
    end

    // Finished reply with the live count attached
    always_comb begin
        w_res_out          = r_res;
        w_res_out.occupied = 4'(r_live);
    end

    assign w_load = (r_state == S_DONE) && (!r_ovalid || i_out_ready);

    cht_ram #(
        .WIDTH (EW),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_slot),
        .i_wdata (EW'(w_wentry)),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    cht_evict #(
        .SLOTS (SLOTS)
    ) u_evict (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_ev_start),
        .o_done  (w_ev_done),
        .o_slot  (w_ev_slot)
    );

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_live   <= '0;
            r_id     <= '0;
            r_pend   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_in    <= i_in_data;
                        r_res   <= w_res_init;
                        r_chunk <= '0;
                        r_idx   <= '0;
                        r_pend  <= 1'b0;
                        r_freed <= '0;
                        case (i_in_data.kind)
                            KIND_CREATE: begin
                                if (i_in_data.handler_tag == 16'd0) begin
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_SEARCH;
                                end
                            end
                            KIND_FIRE:  r_state <= S_FIRE;
                            KIND_PRUNE: r_state <= S_PRUNE;
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SEARCH: begin
                    if (w_any) begin
                        r_slot    <= w_found_full[SW-1:0];
                        r_evicted <= 1'b0;
                        r_state   <= S_CWR;
                    end else if (w_last_chunk) begin
                        r_evicted <= 1'b1;
                        r_state   <= S_EVICT;
                    end else begin
                        r_chunk <= r_chunk + CW'(1);
                    end
                end
                S_EVICT: begin
                    if (w_ev_done) begin
                        r_slot  <= w_ev_slot;
                        r_state <= S_CWR;
                    end
                end
                S_CWR: begin
                    r_valid[r_slot] <= 1'b1;
                    r_id <= w_id_next;
                    if (!r_evicted) begin
                        r_live <= r_live + LW'(1);
                    end
                    r_res.status     <= ST_CREATED;
                    r_res.new_handle <= {16'(r_slot), w_id_next};
                    r_res.evicted    <= r_evicted;
                    r_state <= S_DONE;
                end
                S_FIRE: begin
                    if (w_fmatch) begin
                        r_valid[w_fslot]    <= 1'b0;
                        r_live              <= r_live - LW'(1);
                        r_res.status        <= ST_FIRED;
                        r_res.found_handler <= w_rentry.handler;
                        r_res.found_context <= w_rentry.context_tag;
                    end else begin
                        r_res.status <= ST_NOT_FOUND;
                    end
                    r_state <= S_DONE;
                end
                S_PRUNE: begin
                    // Issue one read a cycle, check the entry read the cycle before
                    if (!w_idx_end) begin
                        r_pidx <= r_idx[SW-1:0];
                        r_idx  <= r_idx + (SW + 1)'(1);
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                    end
                    if (w_old) begin
                        r_valid[r_pidx] <= 1'b0;
                        r_live  <= r_live - LW'(1);
                        r_freed <= r_freed + LW'(1);
                    end
                    if (w_idx_end && !r_pend) begin
                        r_res.status      <= ST_PRUNED;
                        r_res.freed_count <= 4'(r_freed);
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // Hand the word to the output register once it is free
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Load the output register; drop valid once the word is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
            r_out    <= w_res_out;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    // Live count tracks the valid bits
    a_live_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live == LW'($countones(r_valid)))
        else $error("live count out of step with valid bits");

    // Eviction only when every slot is taken
    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ev_start |-> (&r_valid))
        else $error("eviction started with a free slot");

    // A created handle names a slot in range
    a_handle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == ST_CREATED)
        |-> (o_out_data.new_handle[31:16] < 16'(SLOTS)))
        else $error("created handle slot out of range");

endmodule

FILE: tb/sv/cht_reply_checker.sv
`timescale 1ns / 100ps

module cht_reply_checker
    import cht_pkg::*;
#(
    parameter int SLOTS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_word  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_word i_out_data,
    output int        o_errors,
    output int        o_pending
);

    // Shadow copy of the slot table
    logic               slot_live    [SLOTS];
    logic [15:0]        slot_gen     [SLOTS];
    logic [15:0]        slot_handler [SLOTS];
    logic [15:0]        slot_context [SLOTS];
    logic signed [63:0] slot_born    [SLOTS];
    logic [15:0]        gen_count;
    logic [15:0]        victim_lfsr;

    t_out_word replies_due[$];
    t_out_word due;
    int        mismatches = 0;
    int        reply_count = 0;
    int        reply_backlog = 0;

    assign o_errors  = mismatches;
    assign o_pending = reply_backlog;

    // Apply one request word to the shadow table and return the reply it causes
    function automatic t_out_word table_predict(input t_in_word w);
        t_out_word   r;
        int          s;
        int          k;
        int          live;
        int          freed;
        logic        feedback;
        logic [15:0] slot_sel;
        r        = '0;
        r.status = ST_NOT_FOUND;
        freed    = 0;
        live     = 0;
        case (w.kind)
            KIND_CREATE: begin
                if (w.handler_tag == 16'd0) begin
                    r.status = ST_NO_HANDLER;
                end else begin
                    // Lowest free slot, else a victim picked by the LFSR
                    s = SLOTS;
                    for (k = SLOTS - 1; k >= 0; k--) begin
                        if (!slot_live[k]) s = k;
                    end
                    if (s == SLOTS) begin
                        feedback    = victim_lfsr[0] ^ victim_lfsr[2] ^ victim_lfsr[3]
                                      ^ victim_lfsr[5];
                        victim_lfsr = {feedback, victim_lfsr[15:1]};
                        s           = int'(victim_lfsr) % SLOTS;
                        r.evicted   = 1'b1;
                    end
                    // Id counter never takes zero
                    gen_count = gen_count + 16'd1;
                    if (gen_count == 16'd0) gen_count = 16'd1;
                    slot_live[s]    = 1'b1;
                    slot_gen[s]     = gen_count;
                    slot_handler[s] = w.handler_tag;
                    slot_context[s] = w.context_tag;
                    slot_born[s]    = w.now;
                    r.new_handle    = {16'(s), gen_count};
                    r.status        = ST_CREATED;
                end
            end
            KIND_FIRE: begin
                slot_sel = w.handle[31:16];
                if (slot_sel < SLOTS && slot_live[slot_sel]
                        && slot_gen[slot_sel] == w.handle[15:0]) begin
                    r.found_handler     = slot_handler[slot_sel];
                    r.found_context     = slot_context[slot_sel];
                    slot_live[slot_sel] = 1'b0;
                    r.status            = ST_FIRED;
                end
            end
            KIND_PRUNE: begin
                for (k = 0; k < SLOTS; k++) begin
                    if (slot_live[k] && $signed(slot_born[k]) < $signed(w.time_limit)) begin
                        slot_live[k] = 1'b0;
                        freed++;
                    end
                end
                r.freed_count = 4'(freed);
                r.status      = ST_PRUNED;
            end
            default: begin
            end
        endcase
        for (k = 0; k < SLOTS; k++) begin
            if (slot_live[k]) live++;
        end
        r.occupied = 4'(live);
        return r;
    endfunction

    // Compare each reply word with the oldest expectation, then log new requests
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SLOTS; k++) slot_live[k] = 1'b0;
            gen_count   = 16'd0;
            victim_lfsr = LFSR_SEED;
            replies_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                reply_count++;
                if (replies_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("reply %0d arrived with no request waiting", reply_count);
                end else begin
                    due = replies_due.pop_front();
                    if (due.status !== i_out_data.status
                            || due.new_handle !== i_out_data.new_handle
                            || due.evicted !== i_out_data.evicted
                            || due.found_handler !== i_out_data.found_handler
                            || due.found_context !== i_out_data.found_context
                            || due.freed_count !== i_out_data.freed_count
                            || due.occupied !== i_out_data.occupied) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"reply %0d mismatch: expected st=%0d hdl=%h ev=%0d ",
                                      "fh=%h fc=%h freed=%0d occ=%0d, got st=%0d hdl=%h ",
                                      "ev=%0d fh=%h fc=%h freed=%0d occ=%0d"},
                                     reply_count, due.status, due.new_handle, due.evicted,
                                     due.found_handler, due.found_context, due.freed_count,
                                     due.occupied, i_out_data.status, i_out_data.new_handle,
                                     i_out_data.evicted, i_out_data.found_handler,
                                     i_out_data.found_context, i_out_data.freed_count,
                                     i_out_data.occupied);
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                replies_due.push_back(table_predict(i_in_data));
        end
        reply_backlog <= replies_due.size();
    end

endmodule

FILE: tb/sv/tb_callback_handle_table.sv
`timescale 1ns / 100ps

module tb_callback_handle_table;
    import cht_pkg::*;

    localparam int                 SLOTS       = 8;
    localparam logic [1:0]         KIND_UNUSED = 2'd3;
    localparam logic signed [63:0] T_MIN       = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] T_MAX       = 64'sh7FFF_FFFF_FFFF_FFFF;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_word  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_word o_out_data;

    int                 errors;
    int                 pending;
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    logic               out_hold = 1'b0;
    logic signed [63:0] clock_us;
    logic [31:0]        live_handles[$];

    always #5 i_clk = ~i_clk;

    callback_handle_table #(
        .SLOTS (SLOTS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    cht_reply_checker #(
        .SLOTS (SLOTS)
    ) i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out_data  (o_out_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // Stall the reply channel at random, or hold it off entirely
    always @(posedge i_clk) begin
        i_out_ready <= !out_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    // Keep recent handles so fire requests mostly hit live entries
    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready && o_out_data.status == ST_CREATED) begin
            live_handles.push_back(o_out_data.new_handle);
            if (live_handles.size() > 16) void'(live_handles.pop_front());
        end
    end

    function automatic t_in_word request(input logic [1:0] kind, input logic [15:0] handler,
                                         input logic [15:0] context_tag,
                                         input logic signed [63:0] stamp,
                                         input logic [31:0] handle,
                                         input logic signed [63:0] limit);
        t_in_word w;
        w.kind        = kind;
        w.handler_tag = handler;
        w.context_tag = context_tag;
        w.now         = stamp;
        w.handle      = handle;
        w.time_limit  = limit;
        return w;
    endfunction

    // Offer one word, idling first at random; hold it until accepted
    task automatic send_word(input t_in_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Drop valid and wait until every reply is back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Mostly well-formed traffic over random field content, plus noise
    task automatic send_random_request();
        t_in_word w;
        int       pick;
        w.kind        = 2'($urandom);
        w.handler_tag = 16'($urandom);
        w.context_tag = 16'($urandom);
        w.now         = {$urandom, $urandom};
        w.handle      = $urandom;
        w.time_limit  = {$urandom, $urandom};
        clock_us      = clock_us + 64'($urandom_range(40));
        pick          = $urandom_range(99);
        if (pick < 45) begin
            w.kind = KIND_CREATE;
            w.now  = clock_us;
            if ($urandom_range(19) == 0) w.handler_tag = 16'd0;
        end else if (pick < 80) begin
            w.kind = KIND_FIRE;
            if (live_handles.size() > 0 && $urandom_range(9) < 8)
                w.handle = live_handles[$urandom_range(live_handles.size() - 1)];
            else if ($urandom_range(1) == 0)
                w.handle = {16'($urandom_range(SLOTS - 1)), 16'($urandom)};
        end else if (pick < 92) begin
            w.kind       = KIND_PRUNE;
            w.time_limit = clock_us - 64'($urandom_range(600));
        end else if (pick < 96) begin
            w.kind = KIND_UNUSED;
        end
        send_word(w);
    endtask

    initial begin
        #40_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        clock_us = {$urandom, $urandom};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty table: missing handler, fire on a free slot, prune, unused kind
        send_word(request(KIND_CREATE, 16'h0000, 16'hFFFF, T_MAX, '1, T_MIN));
        send_word(request(KIND_FIRE, 16'h0000, 16'h0000, 64'sd0, 32'h0000_0001, 64'sd0));
        send_word(request(KIND_PRUNE, 16'hFFFF, 16'hFFFF, T_MIN, '1, T_MAX));
        send_word(request(KIND_UNUSED, 16'hFFFF, 16'hFFFF, T_MAX, '1, T_MAX));
        // Fill all slots with extreme tags and times
        send_word(request(KIND_CREATE, 16'hFFFF, 16'h0000, T_MIN, '0, '0));
        send_word(request(KIND_CREATE, 16'h0001, 16'hFFFF, T_MAX, '0, '0));
        send_word(request(KIND_CREATE, 16'h8000, 16'h0001, 64'sd0, '0, '0));
        send_word(request(KIND_CREATE, 16'h0001, 16'h8000, -64'sd1, '0, '0));
        send_word(request(KIND_CREATE, 16'h5555, 16'hAAAA, 64'sd100, '0, '0));
        send_word(request(KIND_CREATE, 16'hAAAA, 16'h5555, -64'sd100, '0, '0));
        send_word(request(KIND_CREATE, 16'h1234, 16'h4321, 64'sd200, '0, '0));
        send_word(request(KIND_CREATE, 16'h00FF, 16'hFF00, 64'sd300, '0, '0));
        // Full table: evict
        send_word(request(KIND_CREATE, 16'h0F0F, 16'hF0F0, 64'sd400, '0, '0));
        send_word(request(KIND_CREATE, 16'hF0F0, 16'h0F0F, 64'sd500, '0, '0));
        // Fire: match, stale repeat, id mismatch, slot out of range
        send_word(request(KIND_FIRE, '0, '0, '0, 32'h0001_0002, '0));
        send_word(request(KIND_FIRE, '0, '0, '0, 32'h0001_0002, '0));
        send_word(request(KIND_FIRE, '0, '0, '0, 32'h0002_FFFF, '0));
        send_word(request(KIND_FIRE, '0, '0, '0, 32'hFFFF_0003, '0));
        send_word(request(KIND_FIRE, '0, '0, '0, 32'h0008_0003, '0));
        // Prune across the sign boundary, then at both extremes
        send_word(request(KIND_PRUNE, '0, '0, '0, '0, 64'sd0));
        send_word(request(KIND_CREATE, 16'h7777, 16'h8888, 64'sd600, '0, '0));
        send_word(request(KIND_PRUNE, '0, '0, '0, '0, T_MAX));
        send_word(request(KIND_PRUNE, '0, '0, '0, '0, T_MIN));
        send_word(request(KIND_FIRE, '0, '0, '0, 32'h0007_0008, '0));
        wait_drained();

        // Fill the table, then keep it full so that later creates evict
        repeat (40)
            send_word(request(KIND_CREATE, 16'($urandom_range(16'hFFFF, 1)), 16'($urandom),
                              clock_us + 64'($urandom_range(100)), $urandom, '0));

        // Random traffic; the first phase opens with a long reply hold-off
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            if (phase == 0) begin
                fork
                    begin
                        out_hold <= 1'b1;
                        repeat (300) @(posedge i_clk);
                        out_hold <= 1'b0;
                    end
                join_none
            end
            repeat (300) send_random_request();
        end

        wait_drained();
        repeat (SLOTS + 8) @(posedge i_clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
